[hw/rtl/bct_pkg.sv]
`default_nettype none
package bct_pkg;

	localparam int NUM_BLOCKS_DEF = 64;
	localparam int FILE_W  = 16;
	localparam int BLOCK_W = 36;
	localparam int SLOT_W  = 6;

	// request function codes
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;
	localparam logic [1:0] FUNC_PURGE = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [FILE_W-1:0]  file_id;
		logic [BLOCK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               victim_valid;
		logic               writeback;
		logic [FILE_W-1:0]  victim_file;
		logic [BLOCK_W-1:0] victim_block;
		logic               last;
	} rsp_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic [FILE_W-1:0]  file;
		logic [BLOCK_W-1:0] block;
		logic               upd;
		logic               hit;
		logic               write;
		logic               mark;
		logic               purge;
	} cell_ctl_t;

	// per-cell status seen by the sequencer
	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [FILE_W-1:0]  file;
		logic [BLOCK_W-1:0] block;
		logic               match;
		logic               pend;
	} cell_st_t;

endpackage
`default_nettype wire

[hw/rtl/bct_cell.sv]
`default_nettype none
module bct_cell #(
	parameter int NUM_BLOCKS = bct_pkg::NUM_BLOCKS_DEF,
	parameter int RANK_INIT  = 0,
	localparam int IW = $clog2(NUM_BLOCKS)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bct_pkg::cell_ctl_t  ctl,
	input  wire                 sel,
	input  wire                 act,
	input  wire  [IW-1:0]       sel_rank,
	input  wire                 above_in,
	output bct_pkg::cell_st_t   st,
	output logic [IW-1:0]       rank,
	output logic                above_out
);
	import bct_pkg::*;

	logic               valid_q;
	logic               dirty_q;
	logic               pend_q;
	logic [FILE_W-1:0]  file_q;
	logic [BLOCK_W-1:0] block_q;
	logic [IW-1:0]      rank_q;
	logic               file_eq;

	// own tag compare
	assign file_eq = (file_q == ctl.file);

	always_comb begin
		st.valid = valid_q;
		st.dirty = dirty_q;
		st.file  = file_q;
		st.block = block_q;
		st.match = valid_q && file_eq && (block_q == ctl.block);
		st.pend  = pend_q;
	end

	assign rank = rank_q;

	// pending chain down from the upper slots: high if this or any higher slot is pending
	assign above_out = pend_q | above_in;

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			pend_q  <= 1'b0;
			file_q  <= '0;
			block_q <= '0;
			rank_q  <= IW'(RANK_INIT);
		end else begin
			if (ctl.upd) begin
				if (sel) begin
					rank_q  <= '0;
					valid_q <= 1'b1;
					file_q  <= ctl.file;
					block_q <= ctl.block;
					dirty_q <= ctl.write | (ctl.hit & dirty_q);
				end else if (rank_q < sel_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			if (ctl.mark) begin
				pend_q <= valid_q && file_eq && (ctl.purge || dirty_q);
			end
			if (act) begin
				pend_q  <= 1'b0;
				dirty_q <= 1'b0;
				if (ctl.purge) begin
					valid_q <= 1'b0;
					file_q  <= '0;
					block_q <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/block_cache_tag_lru.sv]
// channel | signals                | beat taken when
// --------+------------------------+----------------------------
// request | start, busy, req       | start high and busy low
// result  | done, result           | done high (one cycle only)
//
// read/write lookup: busy through the LOOK and UPD states; the result is registered in UPD.
// flush/purge: LOOK marks the affected slots, then SCAN visits one slot per
// cycle from slot 0 up to the last affected slot (at least one), as a single
// scan pointer walks the cell row.
// reset clears all slots and sets slot i to recency rank i.
// the receiver cannot stall; results are never held.
`default_nettype none
module block_cache_tag_lru #(
	parameter int NUM_BLOCKS = bct_pkg::NUM_BLOCKS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	output logic         busy,
	input  bct_pkg::req_t req,
	output logic         done,
	output bct_pkg::rsp_t result
);
	import bct_pkg::*;

	localparam int IW = $clog2(NUM_BLOCKS);

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD, S_SCAN} state_t;

	state_t          state_q;
	req_t            req_q;
	logic            hit_q;
	logic [IW-1:0]   sel_idx_q;
	logic [IW-1:0]   sel_rank_q;
	logic [IW-1:0]   idx_q;
	logic            done_q;
	rsp_t            result_q;

	cell_ctl_t       ctl;
	cell_st_t        st   [NUM_BLOCKS];
	logic [IW-1:0]   rank [NUM_BLOCKS];
	logic [NUM_BLOCKS:0] chain;
	logic [NUM_BLOCKS-1:0] sel_vec;
	logic [NUM_BLOCKS-1:0] act_vec;

	logic            hit_any;
	logic [IW-1:0]   hit_idx;
	logic [IW-1:0]   lru_idx;
	logic [IW-1:0]   pick_rank;
	logic            is_lookup;

	assign is_lookup = (req_q.func == FUNC_READ) || (req_q.func == FUNC_WRITE);
	assign chain[NUM_BLOCKS] = 1'b0;

	// broadcast control
	always_comb begin
		ctl.file  = req_q.file_id;
		ctl.block = req_q.block_number;
		ctl.upd   = (state_q == S_UPD);
		ctl.hit   = hit_q;
		ctl.write = (req_q.func == FUNC_WRITE);
		ctl.mark  = (state_q == S_LOOK) && !is_lookup;
		ctl.purge = (req_q.func == FUNC_PURGE);
	end

	// match and lru encode of one-hot inputs into binary slot indices
	always_comb begin
		hit_any   = 1'b0;
		hit_idx   = '0;
		lru_idx   = '0;
		pick_rank = '0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			hit_any = hit_any | st[i].match;
			if (st[i].match)
				hit_idx = hit_idx | IW'(i);
			if (rank[i] == IW'(NUM_BLOCKS - 1))
				lru_idx = lru_idx | IW'(i);
		end
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			if (hit_any ? st[i].match : (rank[i] == IW'(NUM_BLOCKS - 1)))
				pick_rank = pick_rank | rank[i];
		end
	end

	// per-cell selects
	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			sel_vec[i] = (sel_idx_q == IW'(i));
			act_vec[i] = (state_q == S_SCAN) && (idx_q == IW'(i)) && st[i].pend;
		end
	end

	// cell row
	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		bct_cell #(
			.NUM_BLOCKS (NUM_BLOCKS),
			.RANK_INIT  (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (sel_vec[g]),
			.act       (act_vec[g]),
			.sel_rank  (sel_rank_q),
			.above_in  (chain[g+1]),
			.st        (st[g]),
			.rank      (rank[g]),
			.above_out (chain[g])
		);
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
			hit_q      <= 1'b0;
			sel_idx_q  <= '0;
			sel_rank_q <= '0;
			idx_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q      <= hit_any;
					sel_idx_q  <= hit_any ? hit_idx : lru_idx;
					sel_rank_q <= pick_rank;
					idx_q      <= '0;
					state_q    <= is_lookup ? S_UPD : S_SCAN;
				end
				S_UPD: begin
					done_q                <= 1'b1;
					result_q.hit          <= hit_q;
					result_q.slot         <= SLOT_W'(sel_idx_q);
					result_q.last         <= 1'b1;
					if (!hit_q && st[sel_idx_q].valid) begin
						result_q.victim_valid <= 1'b1;
						result_q.writeback    <= st[sel_idx_q].dirty;
						result_q.victim_file  <= st[sel_idx_q].file;
						result_q.victim_block <= st[sel_idx_q].block;
					end else begin
						result_q.victim_valid <= 1'b0;
						result_q.writeback    <= 1'b0;
						result_q.victim_file  <= '0;
						result_q.victim_block <= '0;
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (st[idx_q].pend) begin
						done_q                <= 1'b1;
						result_q.hit          <= 1'b0;
						result_q.slot         <= SLOT_W'(idx_q);
						result_q.victim_valid <= ctl.purge;
						result_q.writeback    <= !ctl.purge;
						result_q.victim_file  <= st[idx_q].file;
						result_q.victim_block <= st[idx_q].block;
						result_q.last         <= !chain[idx_q+1];
					end
					if (!chain[idx_q+1])
						state_q <= S_IDLE;
					else
						idx_q <= idx_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[hw/rtl/bct_check.sv]
`default_nettype none
module bct_check (
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input bct_pkg::req_t req,
	input wire           done,
	input bct_pkg::rsp_t result
);
	import bct_pkg::*;

	// a taken request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request beat did not raise busy");

	// results only follow a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work in progress");

	// final beat frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last) |-> !busy)
		else $error("still busy after final beat");

	// hit is a single clean beat
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.last && !result.victim_valid && !result.writeback))
		else $error("hit beat carries victim data");

	// no victim report means empty tag fields
	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.victim_valid && !result.writeback) |->
		(result.victim_file == '0 && result.victim_block == '0))
		else $error("victim tag without victim");

endmodule

bind block_cache_tag_lru bct_check u_bct_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);
`default_nettype wire

[sim/block_cache_tag_lru_tb.sv]
`default_nettype none
module block_cache_tag_lru_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bct_pkg::*;

	localparam int SLOTS = 64;
	localparam int RAND_ITEMS = 134;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t result;

	block_cache_tag_lru #(.NUM_BLOCKS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .result(result)
	);

	always #10 clk = ~clk;

	// shadow copy of the tag store
	logic               sh_valid [SLOTS];
	logic [FILE_W-1:0]  sh_file  [SLOTS];
	logic [BLOCK_W-1:0] sh_block [SLOTS];
	logic               sh_dirty [SLOTS];
	logic [SLOT_W-1:0]  sh_rank  [SLOTS];

	rsp_t expected_rsp_q[$];
	req_t pending_req_q[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// move a slot to the most recent position
	function automatic void promote_slot(input int s);
		logic [SLOT_W-1:0] r;
		r = sh_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (sh_rank[i] < r) sh_rank[i] = sh_rank[i] + 1'b1;
		sh_rank[s] = '0;
	endfunction

	// apply one request to the shadow store and queue its results
	function automatic void predict_tag_access(input req_t q);
		rsp_t r;
		int found;
		int n;
		int lastidx;
		found = -1;
		if (q.func == FUNC_READ || q.func == FUNC_WRITE) begin
			r = '0;
			for (int i = 0; i < SLOTS; i++)
				if (found < 0 && sh_valid[i] && sh_file[i] == q.file_id
						&& sh_block[i] == q.block_number)
					found = i;
			if (found >= 0) begin
				r.hit = 1'b1;
			end else begin
				found = 0;
				for (int i = 0; i < SLOTS; i++)
					if (sh_rank[i] == SLOT_W'(SLOTS - 1)) found = i;
				if (sh_valid[found]) begin
					r.victim_valid = 1'b1;
					r.writeback = sh_dirty[found];
					r.victim_file = sh_file[found];
					r.victim_block = sh_block[found];
				end
				sh_valid[found] = 1'b1;
				sh_file[found] = q.file_id;
				sh_block[found] = q.block_number;
				sh_dirty[found] = 1'b0;
			end
			promote_slot(found);
			if (q.func == FUNC_WRITE) sh_dirty[found] = 1'b1;
			r.slot = SLOT_W'(found);
			r.last = 1'b1;
			expected_rsp_q.push_back(r);
		end else begin
			n = 0;
			lastidx = expected_rsp_q.size();
			for (int i = 0; i < SLOTS; i++) begin
				if (!sh_valid[i] || sh_file[i] != q.file_id) continue;
				if (q.func == FUNC_FLUSH && !sh_dirty[i]) continue;
				r = '0;
				r.slot = SLOT_W'(i);
				r.victim_file = sh_file[i];
				r.victim_block = sh_block[i];
				if (q.func == FUNC_FLUSH) begin
					r.writeback = 1'b1;
					sh_dirty[i] = 1'b0;
				end else begin
					r.victim_valid = 1'b1;
					sh_valid[i] = 1'b0;
					sh_dirty[i] = 1'b0;
					sh_file[i] = '0;
					sh_block[i] = '0;
				end
				expected_rsp_q.push_back(r);
				n++;
			end
			if (n > 0) expected_rsp_q[lastidx + n - 1].last = 1'b1;
		end
	endfunction

	function automatic req_t make_req(input logic [1:0] f, input logic [FILE_W-1:0] fid,
			input logic [BLOCK_W-1:0] blk);
		req_t q;
		q.func = f;
		q.file_id = fid;
		q.block_number = blk;
		return q;
	endfunction

	// random request: mostly a small working set so hits, evictions and flushes matter
	function automatic req_t rand_req();
		logic [FILE_W-1:0] fid;
		logic [BLOCK_W-1:0] blk;
		int k;
		k = $urandom_range(0, 99);
		if (k < 80) fid = FILE_W'($urandom_range(0, 5));
		else fid = FILE_W'($urandom);
		if ($urandom_range(0, 9) < 7) blk = BLOCK_W'($urandom_range(0, 40));
		else blk = {4'($urandom), 32'($urandom)};
		k = $urandom_range(0, 99);
		if (k < 45) return make_req(FUNC_READ, fid, blk);
		if (k < 85) return make_req(FUNC_WRITE, fid, blk);
		if (k < 94) return make_req(FUNC_FLUSH, fid, {4'($urandom), 32'($urandom)});
		return make_req(FUNC_PURGE, fid, {4'($urandom), 32'($urandom)});
	endfunction

	// stimulus
	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			sh_valid[i] = 1'b0;
			sh_file[i] = '0;
			sh_block[i] = '0;
			sh_dirty[i] = 1'b0;
			sh_rank[i] = SLOT_W'(i);
		end
		// directed: extremes, miss on empty, hit, flush, purge, empty flush/purge
		pending_req_q.push_back(make_req(FUNC_FLUSH, 16'h0000, '0));
		pending_req_q.push_back(make_req(FUNC_PURGE, 16'hffff, '1));
		pending_req_q.push_back(make_req(FUNC_READ, 16'h0000, '0));
		pending_req_q.push_back(make_req(FUNC_WRITE, 16'hffff, '1));
		pending_req_q.push_back(make_req(FUNC_READ, 16'hffff, '1));
		pending_req_q.push_back(make_req(FUNC_WRITE, 16'h0000, '0));
		pending_req_q.push_back(make_req(FUNC_WRITE, 16'hffff, 36'h0_0000_0001));
		pending_req_q.push_back(make_req(FUNC_READ, 16'hffff, 36'h8_0000_0000));
		pending_req_q.push_back(make_req(FUNC_FLUSH, 16'hffff, '0));
		pending_req_q.push_back(make_req(FUNC_FLUSH, 16'hffff, '0));
		pending_req_q.push_back(make_req(FUNC_WRITE, 16'hffff, '1));
		pending_req_q.push_back(make_req(FUNC_PURGE, 16'hffff, '0));
		pending_req_q.push_back(make_req(FUNC_READ, 16'hffff, '1));
		pending_req_q.push_back(make_req(FUNC_PURGE, 16'h0000, '1));
		pending_req_q.push_back(make_req(FUNC_READ, 16'h5555, 36'h5_5555_5555));
		pending_req_q.push_back(make_req(FUNC_WRITE, 16'haaaa, 36'ha_aaaa_aaaa));
		// fill the store so that eviction of valid dirty slots occurs
		for (int i = 0; i < 70; i++)
			pending_req_q.push_back(make_req(FUNC_WRITE, 16'h0007, BLOCK_W'(i)));
		for (int i = 0; i < RAND_ITEMS; i++)
			pending_req_q.push_back(rand_req());
		stim_done = 1;
	end

	// driver: bursts of start with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				predict_tag_access(req);
				void'(pending_req_q.pop_front());
			end
			if (start && busy) begin
				// hold the beat until it is taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_req_q.size() > 0) begin
				start <= 1'b1;
				req <= pending_req_q[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobed beat is checked against the oldest expectation
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				e = expected_rsp_q.pop_front();
				if (result.hit !== e.hit)
					report_mismatch($sformatf("hit %b exp %b", result.hit, e.hit));
				if (result.slot !== e.slot)
					report_mismatch($sformatf("slot %0d exp %0d", result.slot, e.slot));
				if (result.victim_valid !== e.victim_valid)
					report_mismatch($sformatf("victim_valid %b exp %b",
						result.victim_valid, e.victim_valid));
				if (result.writeback !== e.writeback)
					report_mismatch($sformatf("writeback %b exp %b",
						result.writeback, e.writeback));
				if (result.victim_file !== e.victim_file)
					report_mismatch($sformatf("victim_file %h exp %h",
						result.victim_file, e.victim_file));
				if (result.victim_block !== e.victim_block)
					report_mismatch($sformatf("victim_block %h exp %h",
						result.victim_block, e.victim_block));
				if (result.last !== e.last)
					report_mismatch($sformatf("last %b exp %b", result.last, e.last));
			end
		end
	end

	// reset, end of run and timeout
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 10) @(posedge clk);
		if (errors == 0 && expected_rsp_q.size() == 0)
			$display("block_cache_tag_lru_tb: PASS");
		else
			$display("block_cache_tag_lru_tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("block_cache_tag_lru_tb: FAIL");
			$finish;
		end
	end
endmodule
`default_nettype wire

[filelist.f]
hw/rtl/bct_pkg.sv
hw/rtl/bct_cell.sv
hw/rtl/block_cache_tag_lru.sv
hw/rtl/bct_check.sv
sim/block_cache_tag_lru_tb.sv
